// ===== design/vertex_transform_clip_viewport_top_macros.svh =====
// assertion macros for the vertex transform block
// expects clk and rst_n in the scope of use
`ifndef VERTEX_TRANSFORM_CLIP_VIEWPORT_TOP_MACROS_SVH
`define VERTEX_TRANSFORM_CLIP_VIEWPORT_TOP_MACROS_SVH

// same-cycle implication
`define VTCV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VTCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vtcv_pkg.sv =====
// shared widths, register codes and helpers of the vertex transform block
// no dependencies
package vtcv_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int LANE_W        = 16;
    localparam int LANES         = 4;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = 36;
    localparam int MAG_W         = 35;
    localparam int DIM_W         = 12;
    localparam int NUM_W         = 52;
    localparam int DEN_W         = 36;
    localparam int Q_W           = 17;
    localparam int DEPTH_SH      = 17;
    localparam int OUT_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } cfg_reg_t;

    // signed coefficient j of a matrix row
    function automatic logic signed [LANE_W-1:0] row_lane(
        input logic [CFG_DATA_W-1:0] row, input int j);
        return signed'(row[j*LANE_W +: LANE_W]);
    endfunction

endpackage

// ===== design/vtcv_if.sv =====
// vertex input and pixel output channels, valid/ready handshake
// no dependencies
interface vtcv_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vtcv_pixel_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [15:0] device_x;
    logic [15:0] device_y;
    logic [15:0] depth;
    modport source (output valid, visible, device_x, device_y, depth, input ready);
    modport sink   (input valid, visible, device_x, device_y, depth, output ready);
endinterface

// ===== design/vertex_transform_clip_viewport_top.sv =====
// vertex transform, homogeneous clip and viewport mapping, top level
// depends on vtcv_pkg, vtcv_if, vtcv_div and the assertion macro header

// One vertex beat enters per clock and one pixel beat leaves per clock while the output
// beat is taken. Stages: matrix products, row sums, clip test, numerator multiply, then
// 17 stages of a restoring divider (one quotient bit each), then the output register.
// The divider depth sets the latency, not the throughput. When the output beat is not
// taken the whole pipe holds, so nothing is lost or repeated. The user must write matrix
// rows and viewport size over the cfg port only while the pipe is empty; the block does
// not enforce it. Clipped vertices come out with visible low and zeros.
module vertex_transform_clip_viewport_top
    import vtcv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    vtcv_vertex_if.sink           vin,
    vtcv_pixel_if.source          vout
);

    `include "vertex_transform_clip_viewport_top_macros.svh"

    // configuration registers
    logic [CFG_DATA_W-1:0] row_reg [LANES];
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                // identity: 1.0 in lane i of row i
                row_reg[i] <= CFG_DATA_W'(1) << (LANE_W * i + FRAC_BITS);
            end
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0:   row_reg[0] <= cfg_wdata;
                REG_ROW1:   row_reg[1] <= cfg_wdata;
                REG_ROW2:   row_reg[2] <= cfg_wdata;
                REG_ROW3:   row_reg[3] <= cfg_wdata;
                REG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // whole pipe moves unless the output beat is stalled
    logic adv;
    logic out_valid_reg;
    assign adv       = !(out_valid_reg && !vout.ready);
    assign vin.ready = adv;

    // stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES][3];
    logic signed [SUM_W-1:0]  cst_reg  [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES][3];
    logic signed [SUM_W-1:0]  cst_next  [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_next[i][0] = PROD_W'(row_lane(row_reg[i], 0) * vin.pos_x);
            prod_next[i][1] = PROD_W'(row_lane(row_reg[i], 1) * vin.pos_y);
            prod_next[i][2] = PROD_W'(row_lane(row_reg[i], 2) * vin.pos_z);
            // w input is 1.0
            cst_next[i] = SUM_W'(row_lane(row_reg[i], 3)) <<< FRAC_BITS;
        end
    end

    // stage 2: row sums
    logic                    v2_reg;
    logic signed [SUM_W-1:0] h_reg  [LANES];
    logic signed [SUM_W-1:0] h_next [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            h_next[i] = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                      + SUM_W'(prod_reg[i][2]) + cst_reg[i];
        end
    end

    // stage 3: clip test and offsets
    logic             v3_reg;
    logic             vis3_reg;
    logic [MAG_W-1:0] xs3_reg;
    logic [MAG_W-1:0] ys3_reg;
    logic [MAG_W-1:0] zs3_reg;
    logic [MAG_W-1:0] w3_reg;
    logic             vis3_next;

    always_comb
    begin
        vis3_next = (h_reg[3] > 0)
                 && (h_reg[0] >= -h_reg[3]) && (h_reg[0] <= h_reg[3])
                 && (h_reg[1] >= -h_reg[3]) && (h_reg[1] <= h_reg[3])
                 && (h_reg[2] >= 0)         && (h_reg[2] <= h_reg[3]);
    end

    // stage 4: numerators 2*num + den and denominator 2*w
    logic             v4_reg;
    logic             vis4_reg;
    logic [NUM_W-1:0] nx4_reg;
    logic [NUM_W-1:0] ny4_reg;
    logic [NUM_W-1:0] nz4_reg;
    logic [DEN_W-1:0] d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vis3_reg <= 1'b0;
            vis4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= vin.valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            vis3_reg <= vis3_next;
            vis4_reg <= vis3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            cst_reg  <= cst_next;
            h_reg    <= h_next;
            // clipped items carry zeros; the divider result is masked later
            xs3_reg  <= vis3_next ? MAG_W'(h_reg[0] + h_reg[3]) : '0;
            ys3_reg  <= vis3_next ? MAG_W'(h_reg[3] - h_reg[1]) : '0;
            zs3_reg  <= vis3_next ? MAG_W'(h_reg[2]) : '0;
            w3_reg   <= vis3_next ? MAG_W'(h_reg[3]) : '0;
            // W * xs * 8 / w in Q12.4, rounded: (16 W xs + w) / (2 w)
            nx4_reg  <= ((NUM_W'(width_reg) * NUM_W'(xs3_reg)) << 4) + NUM_W'(w3_reg);
            ny4_reg  <= ((NUM_W'(height_reg) * NUM_W'(ys3_reg)) << 4) + NUM_W'(w3_reg);
            nz4_reg  <= (NUM_W'(zs3_reg) << DEPTH_SH) + NUM_W'(w3_reg);
            d4_reg   <= DEN_W'(w3_reg) << 1;
        end
    end

    // divider lanes
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qy;
    logic [Q_W-1:0] qz;

    vtcv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_x (
        .clk (clk), .adv (adv), .num (nx4_reg), .den (d4_reg), .quo (qx)
    );
    vtcv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_y (
        .clk (clk), .adv (adv), .num (ny4_reg), .den (d4_reg), .quo (qy)
    );
    vtcv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_z (
        .clk (clk), .adv (adv), .num (nz4_reg), .den (d4_reg), .quo (qz)
    );

    // valid and visible flags ride alongside the divider stages
    logic [Q_W-1:0] dv_reg;
    logic [Q_W-1:0] dvis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg   <= '0;
            dvis_reg <= '0;
        end
        else if (adv)
        begin
            dv_reg   <= {dv_reg[Q_W-2:0], v4_reg};
            dvis_reg <= {dvis_reg[Q_W-2:0], vis4_reg};
        end
    end

    // saturate to 16 bits
    function automatic logic [OUT_W-1:0] sat16(input logic [Q_W-1:0] q);
        return (q > Q_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : q[OUT_W-1:0];
    endfunction

    // output register
    logic             vis_out_reg;
    logic [OUT_W-1:0] dx_reg;
    logic [OUT_W-1:0] dy_reg;
    logic [OUT_W-1:0] dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_out_reg <= dvis_reg[Q_W-1];
            dx_reg      <= dvis_reg[Q_W-1] ? sat16(qx) : '0;
            dy_reg      <= dvis_reg[Q_W-1] ? sat16(qy) : '0;
            dz_reg      <= dvis_reg[Q_W-1] ? sat16(qz) : '0;
        end
    end

    assign vout.valid    = out_valid_reg;
    assign vout.visible  = vis_out_reg;
    assign vout.device_x = dx_reg;
    assign vout.device_y = dy_reg;
    assign vout.depth    = dz_reg;

    // checks
    `VTCV_ASSERT_SAME(a_clip_zero, vout.valid && !vout.visible, vout.device_x == '0 && vout.device_y == '0 && vout.depth == '0, "clipped beat carries nonzero fields")
    `VTCV_ASSERT_SAME(a_span, v3_reg && vis3_reg, xs3_reg <= (w3_reg << 1) && ys3_reg <= (w3_reg << 1) && zs3_reg <= w3_reg, "kept vertex offsets exceed w range")
    `VTCV_ASSERT_NEXT(a_flow, v2_reg && adv, v3_reg, "valid lost between sum and clip stage")

endmodule

// ===== design/vtcv_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on nothing; widths come from the parameters
module vtcv_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 36,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            // quotient fits Q_W bits, so the top part is already below den
            assign rem_in = DEN_W'(num[NUM_W-1:Q_W]);
            assign den_in = den;
            assign low_in = num[Q_W-1:0];
            assign q_in   = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign trial = {rem_in, low_in[Q_W-1]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                den_reg[k] <= den_in;
                low_reg[k] <= {low_in[Q_W-2:0], 1'b0};
                q_reg[k]   <= {q_in[Q_W-2:0], take};
            end
        end
    end

    assign quo = q_reg[Q_W-1];

endmodule

// ===== sim/vertex_transform_clip_viewport_top_test.sv =====
// self-checking testbench of the vertex transform, clip and viewport block
// depends on vtcv_pkg, vtcv_if and vertex_transform_clip_viewport_top from the design folder

module vertex_transform_clip_viewport_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vtcv_pkg::*;

    localparam int SETTLE_CYCLES = 30;     // pipe is 22 deep, plus margin
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;   // cycles with no beat on either side

    typedef struct packed {
        logic        visible;
        logic [15:0] device_x;
        logic [15:0] device_y;
        logic [15:0] depth;
    } pixel_t;

    // scoreboard: predicts one pixel beat per vertex and checks the output stream
    class pixel_scoreboard;
        logic [63:0] row [4];
        logic [11:0] width_px;
        logic [11:0] height_px;
        pixel_t      pending_px[$];
        int          mismatches;
        int          checked;
        int          kept;
        int          clipped;

        function new();
            reset_regs();
        endfunction

        function void reset_regs();
            for (int i = 0; i < 4; i++)
                row[i] = 64'd1 << (FRAC_BITS_DEF + 16 * i);
            width_px  = WIDTH_RST;
            height_px = HEIGHT_RST;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] val);
            case (idx)
                REG_ROW0:   row[0] = val;
                REG_ROW1:   row[1] = val;
                REG_ROW2:   row[2] = val;
                REG_ROW3:   row[3] = val;
                REG_WIDTH:  width_px = val[11:0];
                REG_HEIGHT: height_px = val[11:0];
                default: ;
            endcase
        endfunction

        function longint coef(logic [63:0] r, int j);
            logic signed [15:0] c;
            c = r[16*j +: 16];
            return longint'(c);
        endfunction

        function longint homog(int i, longint x, longint y, longint z);
            return coef(row[i], 0) * x + coef(row[i], 1) * y + coef(row[i], 2) * z
                 + coef(row[i], 3) * (longint'(1) << FRAC_BITS_DEF);
        endfunction

        // round to nearest, half way rounds up, then clamp to 16 bits
        function logic [15:0] quot_sat(bit [63:0] num, bit [63:0] den);
            bit [63:0] q;
            q = (2 * num + den) / (2 * den);
            return (q > 64'd65535) ? 16'hffff : q[15:0];
        endfunction

        function void note_vertex(logic signed [15:0] px, logic signed [15:0] py,
                                  logic signed [15:0] pz);
            longint hx, hy, hz, hw;
            pixel_t e;
            hx = homog(0, px, py, pz);
            hy = homog(1, px, py, pz);
            hz = homog(2, px, py, pz);
            hw = homog(3, px, py, pz);
            e = '0;
            // w <= 0 counts as clipped, which also avoids the divide by zero
            if (!(hw <= 0 || hx < -hw || hx > hw || hy < -hw || hy > hw
                  || hz < 0 || hz > hw)) begin
                e.visible  = 1'b1;
                e.device_x = quot_sat(64'(width_px) * 64'(hx + hw) * 8, 64'(hw));
                e.device_y = quot_sat(64'(height_px) * 64'(hw - hy) * 8, 64'(hw));
                e.depth    = quot_sat(64'(hz) << 16, 64'(hw));
                kept++;
            end else
                clipped++;
            pending_px.insert(pending_px.size(), e);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t e;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel beat: vis=%0b x=%0d y=%0d depth=%0d",
                             got.visible, got.device_x, got.device_y, got.depth);
                return;
            end
            e = pending_px.pop_front();
            checked++;
            if (got.visible !== e.visible || got.device_x !== e.device_x
                || got.device_y !== e.device_y || got.depth !== e.depth) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d mismatch: exp vis=%0b x=%0d y=%0d depth=%0d,",
                             checked, e.visible, e.device_x, e.device_y, e.depth,
                             " got vis=%0b x=%0d y=%0d depth=%0d",
                             got.visible, got.device_x, got.device_y, got.depth);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    vtcv_vertex_if vin_if ();
    vtcv_pixel_if  vout_if ();

    vertex_transform_clip_viewport_top #(.FRAC_BITS(FRAC_BITS_DEF)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .vin       (vin_if),
        .vout      (vout_if)
    );

    pixel_scoreboard sb = new();

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int vertices_sent;
    int config_sets;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // all block inputs known from time zero
    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        vin_if.valid   <= 1'b0;
        vin_if.pos_x   <= '0;
        vin_if.pos_y   <= '0;
        vin_if.pos_z   <= '0;
        vout_if.ready  <= 1'b0;
    end

    // receiver: checks each accepted pixel beat, then picks next ready
    initial
    begin
        int hold_left;
        pixel_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && vout_if.valid && vout_if.ready) begin
                got.visible  = vout_if.visible;
                got.device_x = vout_if.device_x;
                got.device_y = vout_if.device_y;
                got.depth    = vout_if.depth;
                sb.check_pixel(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                vout_if.ready <= 1'b0;
            end else
                vout_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: ends the run when no beat moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((vin_if.valid && vin_if.ready) || (vout_if.valid && vout_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", quiet);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one vertex beat, with a random gap in front of it
    task automatic send_vertex(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            vin_if.valid <= 1'b0;
            @(posedge clk);
        end
        vin_if.valid <= 1'b1;
        vin_if.pos_x <= px;
        vin_if.pos_y <= py;
        vin_if.pos_z <= pz;
        @(posedge clk);
        while (!vin_if.ready)
            @(posedge clk);
        sb.note_vertex(px, py, pz);
        vertices_sent++;
    endtask

    // mostly inside the unit cube so the clip test passes often, some full range noise
    function automatic logic [15:0] coord();
        if ($urandom_range(0, 99) < 75)
            return 16'($signed($urandom_range(0, 8192)) - 4096);
        return 16'($urandom);
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_vertex(coord(), coord(), coord());
    endtask

    // let the pipe drain; needed before any register write
    task automatic drain();
        vin_if.valid <= 1'b0;
        wait (sb.pending_px.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_we after the last write of a group
    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [15:0] lane_rand(int lo, int hi);
        return 16'($signed($urandom_range(0, hi - lo)) + lo);
    endfunction

    // a perspective-like matrix: near-unit diagonal, small cross terms,
    // depth offset positive and w kept mostly positive
    task automatic load_view_matrix(logic [11:0] w_px, logic [11:0] h_px);
        logic [15:0] l [4];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++)
                l[j] = lane_rand(-512, 512);
            if (i < 3)
                l[i] = lane_rand(1024, 4096);
            if (i == 2)
                l[3] = lane_rand(0, 4096);
            if (i == 3)
                l[3] = lane_rand(4096, 8192);
            write_reg(cfg_reg_t'(REG_ROW0 + i), {l[3], l[2], l[1], l[0]});
        end
        write_reg(REG_WIDTH, 64'(w_px));
        write_reg(REG_HEIGHT, 64'(h_px));
        cfg_we <= 1'b0;
        config_sets++;
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        vertices_sent  = 0;
        config_sets    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset matrix (identity) and 640x480 viewport
        send_vertex(16'd0, 16'd0, 16'd0);                 // center, zero depth
        send_vertex(16'd4096, 16'd4096, 16'd4096);        // on the clip boundary, depth saturates
        send_vertex(-16'sd4096, -16'sd4096, 16'd0);       // opposite corner
        send_vertex(16'd4097, 16'd0, 16'd0);              // just outside in x
        send_vertex(16'd0, -16'sd4097, 16'd100);          // just outside in y
        send_vertex(16'd0, 16'd0, -16'sd1);               // behind the near plane
        send_vertex(16'd2048, -16'sd2048, 16'd2048);      // half way points, rounding
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff);        // field extremes
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h7fff, 16'h8000, 16'd0);
        send_vertex(16'd1, 16'd3, 16'd4095);
        drain();

        // zero w: every vertex clipped
        write_reg(REG_ROW3, 64'd0);
        cfg_we <= 1'b0;
        send_vertex(16'd0, 16'd0, 16'd0);
        send_vertex(16'd100, 16'd200, 16'd300);
        drain();

        // negative w, extreme lanes in the other rows
        write_reg(REG_ROW0, 64'h8000_8000_8000_8000);
        write_reg(REG_ROW1, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_ROW2, 64'h7fff_8000_7fff_8000);
        write_reg(REG_ROW3, 64'h8000_0000_0000_0000);
        cfg_we <= 1'b0;
        send_vertex(16'd0, 16'd0, 16'd0);
        send_vertex(16'h8000, 16'h7fff, 16'h8000);
        drain();

        // zero viewport size and the largest one, with identity rows
        for (int i = 0; i < 4; i++)
            write_reg(cfg_reg_t'(REG_ROW0 + i), 64'd1 << (FRAC_BITS_DEF + 16 * i));
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd0);
        cfg_we <= 1'b0;
        send_vertex(16'd1000, -16'sd1000, 16'd500);
        send_vertex(16'd4096, -16'sd4096, 16'd4096);
        drain();
        write_reg(REG_WIDTH, 64'd4095);
        write_reg(REG_HEIGHT, 64'd4095);
        cfg_we <= 1'b0;
        send_vertex(16'd4096, -16'sd4096, 16'd4096);
        send_vertex(-16'sd4096, 16'd4096, 16'd0);
        send_vertex(16'd1, 16'd1, 16'd1);
        drain();

        // random phases, each with its own matrix and idling mode
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (p == 5) begin
                // fully random rows, mostly clipped, covers every register bit
                for (int i = 0; i < 4; i++)
                    write_reg(cfg_reg_t'(REG_ROW0 + i), {$urandom, $urandom});
                write_reg(REG_WIDTH, 64'($urandom_range(1, 4095)));
                write_reg(REG_HEIGHT, 64'($urandom_range(1, 4095)));
                cfg_we <= 1'b0;
                config_sets++;
            end else if (p == 7)
                load_view_matrix(12'd1, 12'd4095);
            else
                load_view_matrix(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));

            if (p == 0) begin
                // long receiver hold-off while vertices keep coming: the pipe fills
                hold_request = 1'b1;
                send_random(120);
                // sender waits for every pixel before going on
                vin_if.valid <= 1'b0;
                wait (sb.pending_px.size() == 0);
                send_random(210);
            end else
                send_random(p == 1 || p == 2 ? 150 : 240);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d vertices over %0d random matrix setups: %0d kept, %0d clipped",
                 vertices_sent, config_sets, sb.kept, sb.clipped);
        $display("%0d pixel beats checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_px.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== vertex_transform_clip_viewport_top.f =====
+incdir+design
design/vtcv_pkg.sv
design/vtcv_if.sv
design/vtcv_div.sv
design/vertex_transform_clip_viewport_top.sv
sim/vertex_transform_clip_viewport_top_test.sv
